// File: hw/rtl/mwcl_pkg.sv
// ----------------------------------------------------------------------------
// mwcl_pkg
// Shared types and constants of the mecanum wheel command limiter.
// ----------------------------------------------------------------------------
package mwcl_pkg;

  // Field widths
  localparam int unsigned VelW    = 21;  // signed Q4.16 body velocity
  localparam int unsigned YawW    = 23;  // signed Q6.16 yaw rate
  localparam int unsigned RateW   = 25;  // signed Q8.16 wheel rate result
  localparam int unsigned IrW     = 24;  // inverse wheel radius
  localparam int unsigned AxisW   = 18;  // half wheelbase plus half track
  localparam int unsigned LimW    = 24;  // wheel speed limit
  localparam int unsigned TickW   = 16;  // watchdog counter and timeout
  localparam int unsigned TwistW  = 25;  // k*wz in Q.16
  localparam int unsigned SumW    = 26;  // vx +/- vy +/- t
  localparam int unsigned RawW    = 34;  // unscaled wheel rate, signed
  localparam int unsigned MagW    = 33;  // magnitude of unscaled rate
  localparam int unsigned FracW   = 16;  // fraction bits
  localparam int unsigned Wheels  = 4;
  localparam int unsigned DivSteps = LimW;  // quotient bits of the scaler

  // Configuration port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes
  localparam logic [1:0] RegInverseRadius = 2'd0;
  localparam logic [1:0] RegAxisOffsetSum = 2'd1;
  localparam logic [1:0] RegSpeedLimit    = 2'd2;
  localparam logic [1:0] RegTimeoutTicks  = 2'd3;

  // Register reset values
  localparam logic [IrW-1:0]   InverseRadiusRst = 24'd1310720;
  localparam logic [AxisW-1:0] AxisOffsetRst    = 18'd20120;
  localparam logic [LimW-1:0]  SpeedLimitRst    = 24'd3276800;
  localparam logic [TickW-1:0] TimeoutRst       = 16'd10;

  // Input item kind and result cause
  localparam logic OpCommand    = 1'b0;
  localparam logic OpTick       = 1'b1;
  localparam logic CauseCommand = 1'b0;
  localparam logic CauseStop    = 1'b1;

  // Wheel order in the result
  localparam logic [1:0] WheelFrontLeft  = 2'd0;
  localparam logic [1:0] WheelFrontRight = 2'd1;
  localparam logic [1:0] WheelRearLeft   = 2'd2;
  localparam logic [1:0] WheelRearRight  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWIST,
    ST_RATE,
    ST_CHECK,
    ST_SCALE_MUL,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [IrW-1:0]   inverse_radius;
    logic [AxisW-1:0] axis_offset_sum;
    logic [LimW-1:0]  wheel_speed_limit;
    logic [TickW-1:0] timeout_ticks;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_in;     // capture command velocities
    logic       load_twist;  // register k*wz
    logic       rate_en;     // compute one wheel rate, track the maximum
    logic       mul_en;      // form one scaler numerator
    logic       div_en;      // one quotient bit on all wheels
    logic       out_load;    // fill the output register
    logic       out_stop;    // result is a watchdog stop
    logic       out_scaled;  // result takes the scaled rates
    logic [1:0] idx;         // wheel select
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic over_limit;  // largest magnitude exceeds the limit
    logic out_free;    // output register can take a result
  } dp_status_t;

endpackage

// File: hw/rtl/mecanum_wheel_command_limiter.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_command_limiter
// A command runs the twist, rate and check states, then the scale and divide
// states (24-step divider on four lanes) if the wheels are scaled to the limit,
// then done; a watchdog stop goes straight to done. One item is in work at a
// time; the next is accepted once the previous one sits in the output register.
// Reset: registers return to their defaults, watchdog disarmed, output empty.
// ----------------------------------------------------------------------------
module mecanum_wheel_command_limiter (
  input  logic           clk_i,
  input  logic           rst_ni,
  // Configuration
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  // Input items
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // velocity_forward[20:0], velocity_sideways[41:21], yaw_rate[64:42], zero fill
  input  logic [71:0]    s_axis_tdata,
  // op[0]
  input  logic           s_axis_tuser,
  // Result items
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // front_left_rate[24:0], front_right_rate[49:25], rear_left_rate[74:50],
  // rear_right_rate[99:75], zero fill
  output logic [103:0]   m_axis_tdata,
  // cause[0]
  output logic           m_axis_tuser
);

  mwcl_pkg::cfg_t       cfg;
  mwcl_pkg::dp_cmd_t    cmd;
  mwcl_pkg::dp_status_t status;

  mwcl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mwcl_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_op_i         (s_axis_tuser),
    .in_ready_o      (s_axis_tready),
    .timeout_ticks_i (cfg.timeout_ticks),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  mwcl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// File: hw/rtl/mwcl_cfg_regs.sv
// ----------------------------------------------------------------------------
// mwcl_cfg_regs
// APB-style register file holding the limiter configuration.
// ----------------------------------------------------------------------------
module mwcl_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwcl_pkg::AddrW-1:0]    paddr,
  input  logic [mwcl_pkg::DataW-1:0]    pwdata,
  output logic [mwcl_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output mwcl_pkg::cfg_t                cfg_o
);

  mwcl_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        mwcl_pkg::RegInverseRadius: cfg_d.inverse_radius    = pwdata[mwcl_pkg::IrW-1:0];
        mwcl_pkg::RegAxisOffsetSum: cfg_d.axis_offset_sum   = pwdata[mwcl_pkg::AxisW-1:0];
        mwcl_pkg::RegSpeedLimit:    cfg_d.wheel_speed_limit = pwdata[mwcl_pkg::LimW-1:0];
        mwcl_pkg::RegTimeoutTicks:  cfg_d.timeout_ticks     = pwdata[mwcl_pkg::TickW-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inverse_radius    <= mwcl_pkg::InverseRadiusRst;
      cfg_q.axis_offset_sum   <= mwcl_pkg::AxisOffsetRst;
      cfg_q.wheel_speed_limit <= mwcl_pkg::SpeedLimitRst;
      cfg_q.timeout_ticks     <= mwcl_pkg::TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      mwcl_pkg::RegInverseRadius: prdata = {8'd0, cfg_q.inverse_radius};
      mwcl_pkg::RegAxisOffsetSum: prdata = {14'd0, cfg_q.axis_offset_sum};
      mwcl_pkg::RegSpeedLimit:    prdata = {8'd0, cfg_q.wheel_speed_limit};
      mwcl_pkg::RegTimeoutTicks:  prdata = {16'd0, cfg_q.timeout_ticks};
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/mwcl_ctrl.sv
// ----------------------------------------------------------------------------
// mwcl_ctrl
// Sequencer for kinematics and scaling, plus the command watchdog.
// ----------------------------------------------------------------------------
module mwcl_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_op_i,
  output logic                            in_ready_o,
  input  logic [mwcl_pkg::TickW-1:0]      timeout_ticks_i,
  input  mwcl_pkg::dp_status_t            status_i,
  output mwcl_pkg::dp_cmd_t               cmd_o
);

  mwcl_pkg::state_e state_q, state_d;
  logic [1:0]                 idx_q, idx_d;
  logic [4:0]                 step_q, step_d;
  logic                       armed_q, armed_d;
  logic [mwcl_pkg::TickW-1:0] ticks_q, ticks_d;
  logic                       stop_q, stop_d;
  logic                       scaled_q, scaled_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mwcl_pkg::ST_IDLE;
      idx_q    <= '0;
      step_q   <= '0;
      armed_q  <= 1'b0;
      ticks_q  <= '0;
      stop_q   <= 1'b0;
      scaled_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      step_q   <= step_d;
      armed_q  <= armed_d;
      ticks_q  <= ticks_d;
      stop_q   <= stop_d;
      scaled_q <= scaled_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    step_d     = step_q;
    armed_d    = armed_q;
    ticks_d    = ticks_q;
    stop_d     = stop_q;
    scaled_d   = scaled_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = idx_q;

    unique case (state_q)
      mwcl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == mwcl_pkg::OpTick) begin
            // Advance the watchdog; stop the wheels once it runs out
            if (armed_q) begin
              if (ticks_q >= timeout_ticks_i) begin
                armed_d  = 1'b0;
                stop_d   = 1'b1;
                scaled_d = 1'b0;
                state_d  = mwcl_pkg::ST_DONE;
              end else begin
                ticks_d = ticks_q + 1'b1;
              end
            end
          end else begin
            cmd_o.load_in = 1'b1;
            armed_d       = 1'b1;
            ticks_d       = '0;
            stop_d        = 1'b0;
            state_d       = mwcl_pkg::ST_TWIST;
          end
        end
      end

      mwcl_pkg::ST_TWIST: begin
        cmd_o.load_twist = 1'b1;
        idx_d            = '0;
        state_d          = mwcl_pkg::ST_RATE;
      end

      mwcl_pkg::ST_RATE: begin
        cmd_o.rate_en = 1'b1;
        idx_d         = idx_q + 1'b1;
        if (idx_q == mwcl_pkg::WheelRearRight) begin
          state_d = mwcl_pkg::ST_CHECK;
        end
      end

      mwcl_pkg::ST_CHECK: begin
        scaled_d = status_i.over_limit;
        idx_d    = '0;
        state_d  = status_i.over_limit ? mwcl_pkg::ST_SCALE_MUL : mwcl_pkg::ST_DONE;
      end

      mwcl_pkg::ST_SCALE_MUL: begin
        cmd_o.mul_en = 1'b1;
        idx_d        = idx_q + 1'b1;
        step_d       = '0;
        if (idx_q == mwcl_pkg::WheelRearRight) begin
          state_d = mwcl_pkg::ST_DIVIDE;
        end
      end

      mwcl_pkg::ST_DIVIDE: begin
        cmd_o.div_en = 1'b1;
        step_d       = step_q + 1'b1;
        if (step_q == 5'(mwcl_pkg::DivSteps - 1)) begin
          state_d = mwcl_pkg::ST_DONE;
        end
      end

      mwcl_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_stop   = stop_q;
          cmd_o.out_scaled = scaled_q;
          state_d          = mwcl_pkg::ST_IDLE;
        end
      end

      default: state_d = mwcl_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/mwcl_datapath.sv
// ----------------------------------------------------------------------------
// mwcl_datapath
// Kinematics multiplier, peak tracker, four-lane divider and output register.
// ----------------------------------------------------------------------------
module mwcl_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mwcl_pkg::cfg_t                         cfg_i,
  input  mwcl_pkg::dp_cmd_t                      cmd_i,
  output mwcl_pkg::dp_status_t                   status_o,
  input  logic [71:0]                            in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [103:0]                           out_data_o,
  output logic                                   out_user_o
);

  localparam int unsigned TwProdW = mwcl_pkg::AxisW + 1 + mwcl_pkg::YawW;  // 42
  localparam int unsigned RtProdW = mwcl_pkg::SumW + mwcl_pkg::IrW + 1;    // 51
  localparam int unsigned NumW    = mwcl_pkg::MagW + mwcl_pkg::LimW;       // 57

  // Captured command
  logic signed [mwcl_pkg::VelW-1:0]   vx_q, vy_q;
  logic signed [mwcl_pkg::YawW-1:0]   wz_q;
  logic signed [mwcl_pkg::TwistW-1:0] t_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      vx_q <= in_data_i[20:0];
      vy_q <= in_data_i[41:21];
      wz_q <= in_data_i[64:42];
    end
  end

  // t = k*wz in Q.16, truncated toward zero
  logic signed [TwProdW-1:0] tw_prod, tw_adj;
  assign tw_prod = $signed({1'b0, cfg_i.axis_offset_sum}) * wz_q;
  assign tw_adj  = tw_prod + (tw_prod[TwProdW-1] ? TwProdW'(16'hFFFF) : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_twist) begin
      t_q <= tw_adj[mwcl_pkg::FracW +: mwcl_pkg::TwistW];
    end
  end

  // Wheel sum for the selected wheel
  logic signed [mwcl_pkg::SumW-1:0] vx_e, vy_e, t_e, sum;
  assign vx_e = mwcl_pkg::SumW'(vx_q);
  assign vy_e = mwcl_pkg::SumW'(vy_q);
  assign t_e  = mwcl_pkg::SumW'(t_q);

  always_comb begin
    unique case (cmd_i.idx)
      mwcl_pkg::WheelFrontLeft:  sum = vx_e - vy_e - t_e;
      mwcl_pkg::WheelFrontRight: sum = vx_e + vy_e + t_e;
      mwcl_pkg::WheelRearLeft:   sum = vx_e + vy_e - t_e;
      mwcl_pkg::WheelRearRight:  sum = vx_e - vy_e + t_e;
      default:                   sum = '0;
    endcase
  end

  // Wheel rate = sum * inverse_radius in Q.16, truncated toward zero
  logic signed [RtProdW-1:0]        rt_prod, rt_adj;
  logic signed [mwcl_pkg::RawW-1:0] rate_new;
  logic [mwcl_pkg::MagW-1:0]        mag_new;

  assign rt_prod  = sum * $signed({1'b0, cfg_i.inverse_radius});
  assign rt_adj   = rt_prod + (rt_prod[RtProdW-1] ? RtProdW'(16'hFFFF) : '0);
  assign rate_new = rt_adj[mwcl_pkg::FracW +: mwcl_pkg::RawW];
  assign mag_new  = rate_new[mwcl_pkg::RawW-1] ? mwcl_pkg::MagW'(-rate_new)
                                               : mwcl_pkg::MagW'(rate_new);

  logic signed [mwcl_pkg::RawW-1:0] rate_q [mwcl_pkg::Wheels];
  logic [mwcl_pkg::MagW-1:0]        max_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rate_en) begin
      rate_q[cmd_i.idx] <= rate_new;
    end
  end

  // Track the largest magnitude; clear it with each new command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
    end else if (cmd_i.load_in) begin
      max_q <= '0;
    end else if (cmd_i.rate_en && (mag_new > max_q)) begin
      max_q <= mag_new;
    end
  end

  assign status_o.over_limit = max_q > mwcl_pkg::MagW'(cfg_i.wheel_speed_limit);

  // Scaler numerator mag*limit for the selected wheel
  logic signed [mwcl_pkg::RawW-1:0] rate_sel;
  logic [mwcl_pkg::MagW-1:0]        mag_sel;
  logic [NumW-1:0]                  num;

  assign rate_sel = rate_q[cmd_i.idx];
  assign mag_sel  = rate_sel[mwcl_pkg::RawW-1] ? mwcl_pkg::MagW'(-rate_sel)
                                               : mwcl_pkg::MagW'(rate_sel);
  assign num      = mag_sel * cfg_i.wheel_speed_limit;

  // Restoring divider lanes: quotient does not exceed the limit
  logic [mwcl_pkg::MagW-1:0] rem_q [mwcl_pkg::Wheels];
  logic [mwcl_pkg::LimW-1:0] quo_q [mwcl_pkg::Wheels];

  for (genvar w = 0; w < mwcl_pkg::Wheels; w++) begin : g_div
    logic [mwcl_pkg::MagW:0] trial;
    logic [mwcl_pkg::MagW:0] diff;

    assign trial = {rem_q[w], quo_q[w][mwcl_pkg::LimW-1]};
    assign diff  = trial - {1'b0, max_q};

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul_en && (cmd_i.idx == 2'(w))) begin
        rem_q[w] <= num[NumW-1 -: mwcl_pkg::MagW];
        quo_q[w] <= num[mwcl_pkg::LimW-1:0];
      end else if (cmd_i.div_en) begin
        if (!diff[mwcl_pkg::MagW]) begin
          rem_q[w] <= diff[mwcl_pkg::MagW-1:0];
          quo_q[w] <= {quo_q[w][mwcl_pkg::LimW-2:0], 1'b1};
        end else begin
          rem_q[w] <= trial[mwcl_pkg::MagW-1:0];
          quo_q[w] <= {quo_q[w][mwcl_pkg::LimW-2:0], 1'b0};
        end
      end
    end
  end

  // Final wheel rates
  logic [mwcl_pkg::RateW-1:0] res [mwcl_pkg::Wheels];

  for (genvar w = 0; w < mwcl_pkg::Wheels; w++) begin : g_res
    logic [mwcl_pkg::RateW-1:0] q_ext;
    assign q_ext = {1'b0, quo_q[w]};

    always_comb begin
      if (cmd_i.out_stop) begin
        res[w] = '0;
      end else if (cmd_i.out_scaled) begin
        res[w] = rate_q[w][mwcl_pkg::RawW-1] ? -q_ext : q_ext;
      end else begin
        res[w] = rate_q[w][mwcl_pkg::RateW-1:0];
      end
    end
  end

  // Output register
  logic         out_valid_q;
  logic [103:0] out_data_q;
  logic         out_user_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {4'd0, res[3], res[2], res[1], res[0]};
      out_user_q <= cmd_i.out_stop ? mwcl_pkg::CauseStop : mwcl_pkg::CauseCommand;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule
